### src/mi3_pkg.sv
// Shared widths, types and saturation constants of the 3x3 inverse pipeline.
package mi3_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int N_ELEM        = 9;
    localparam int N_DIM         = 3;
    localparam int ELEM_W        = 32;
    localparam int PROD_W        = 2 * ELEM_W;
    localparam int COF_W         = PROD_W + 1;
    localparam int PART_W        = COF_W;
    localparam int TERM_W        = COF_W + ELEM_W;
    localparam int DET_W         = TERM_W + 2;
    localparam int Q_W           = 32;
    localparam int WIDE_W        = DET_W + Q_W;
    localparam int TOL_W         = 16;

    localparam logic [Q_W-1:0] SAT_POS = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] SAT_NEG = {1'b1, {(Q_W-1){1'b0}}};

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [COF_W-1:0]  t_cof;
    typedef logic signed [DET_W-1:0]  t_det;
    typedef logic [DET_W-1:0]         t_dabs;
    typedef logic [WIDE_W-1:0]        t_wide;
    typedef logic [Q_W-1:0]           t_quo;

endpackage

### src/mi3_cofactor.sv
// Cofactor stages: 2x2 products, then their differences.
module mi3_cofactor import mi3_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_elem i_mat [N_ELEM],
    output logic  o_valid,
    output t_cof  o_cof [N_ELEM],
    output t_elem o_m0 [N_DIM]
);

    logic  r_va;
    logic  r_vb;
    t_prod r_pa [N_ELEM];
    t_prod r_pb [N_ELEM];
    t_elem r_m0a [N_DIM];
    t_elem r_m0b [N_DIM];
    t_cof  r_cof [N_ELEM];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    genvar c, r;
    generate
        for (c = 0; c < N_DIM; c++) begin : g_col
            for (r = 0; r < N_DIM; r++) begin : g_row
                // element m[col][row] lives at col*3+row
                localparam int I1 = (c + 1) % N_DIM;
                localparam int I2 = (c + 2) % N_DIM;
                localparam int J1 = (r + 1) % N_DIM;
                localparam int J2 = (r + 2) % N_DIM;
                localparam int K  = c * N_DIM + r;
                always_ff @(posedge i_clk) begin
                    r_pa[K]  <= i_mat[J1*N_DIM+I1] * i_mat[J2*N_DIM+I2];
                    r_pb[K]  <= i_mat[J1*N_DIM+I2] * i_mat[J2*N_DIM+I1];
                    r_cof[K] <= COF_W'(r_pa[K]) - COF_W'(r_pb[K]);
                end
            end
            always_ff @(posedge i_clk) begin
                r_m0a[c] <= i_mat[c*N_DIM];
                r_m0b[c] <= r_m0a[c];
            end
        end
    endgenerate

    assign o_valid = r_vb;
    assign o_cof   = r_cof;
    assign o_m0    = r_m0b;

endmodule

### src/mi3_det.sv
// Determinant stages: first-row expansion, each cofactor split at bit 32 in two.
module mi3_det import mi3_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_cof  i_cof [N_ELEM],
    input  t_elem i_m0 [N_DIM],
    output logic  o_valid,
    output t_det  o_det,
    output t_cof  o_cof [N_ELEM]
);

    logic [2:0]               r_v;
    logic signed [PART_W-1:0] r_lo [N_DIM];
    logic signed [PART_W-1:0] r_hi [N_DIM];
    logic signed [TERM_W-1:0] r_term [N_DIM];
    t_det                     r_det;
    t_cof                     r_c1 [N_ELEM];
    t_cof                     r_c2 [N_ELEM];
    t_cof                     r_c3 [N_ELEM];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < N_DIM; r++) begin
            r_lo[r]   <= $signed({1'b0, i_cof[r][ELEM_W-1:0]}) * i_m0[r];
            r_hi[r]   <= $signed(i_cof[r][COF_W-1:ELEM_W]) * i_m0[r];
            r_term[r] <= (TERM_W'(r_hi[r]) <<< ELEM_W) + TERM_W'(r_lo[r]);
        end
        r_det <= DET_W'(r_term[0]) + DET_W'(r_term[1]) + DET_W'(r_term[2]);
        r_c1  <= i_cof;
        r_c2  <= r_c1;
        r_c3  <= r_c2;
    end

    assign o_valid = r_v[2];
    assign o_det   = r_det;
    assign o_cof   = r_c3;

endmodule

### src/mi3_divider.sv
// Nine-lane pipelined restoring divider, one quotient bit per stage.
module mi3_divider import mi3_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_sing,
    input  t_dabs i_d,
    input  t_wide i_num [N_ELEM],
    input  logic  i_neg [N_ELEM],
    output logic  o_valid,
    output logic  o_sing,
    output t_quo  o_q [N_ELEM],
    output logic  o_big [N_ELEM],
    output logic  o_neg [N_ELEM]
);

    localparam int NS = Q_W + 1;

    logic  r_v   [NS];
    logic  r_s   [NS];
    t_dabs r_d   [NS];
    t_wide r_rem [NS][N_ELEM];
    t_quo  r_q   [NS][N_ELEM];
    logic  r_big [NS][N_ELEM];
    logic  r_neg [NS][N_ELEM];

    // first stage flags quotients of 2^32 or more, which saturate anyway
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s[0] <= i_sing;
        r_d[0] <= i_d;
        for (int k = 0; k < N_ELEM; k++) begin
            r_big[0][k] <= i_num[k] >= (WIDE_W'(i_d) << Q_W);
            r_rem[0][k] <= i_num[k];
            r_q[0][k]   <= '0;
            r_neg[0][k] <= i_neg[k];
        end
    end

    genvar s;
    generate
        for (s = 1; s < NS; s++) begin : g_stage
            localparam int   B    = Q_W - s;
            localparam t_quo QBIT = t_quo'(1) << B;
            t_wide dsh;
            assign dsh = WIDE_W'(r_d[s-1]) << B;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[s] <= 1'b0;
                end else begin
                    r_v[s] <= r_v[s-1];
                end
            end

            always_ff @(posedge i_clk) begin
                r_s[s] <= r_s[s-1];
                r_d[s] <= r_d[s-1];
                for (int k = 0; k < N_ELEM; k++) begin
                    r_big[s][k] <= r_big[s-1][k];
                    r_neg[s][k] <= r_neg[s-1][k];
                    if (r_rem[s-1][k] >= dsh) begin
                        r_rem[s][k] <= r_rem[s-1][k] - dsh;
                        r_q[s][k]   <= r_q[s-1][k] | QBIT;
                    end else begin
                        r_rem[s][k] <= r_rem[s-1][k];
                        r_q[s][k]   <= r_q[s-1][k];
                    end
                end
            end
        end
    endgenerate

    assign o_valid = r_v[NS-1];
    assign o_sing  = r_s[NS-1];
    assign o_q     = r_q[NS-1];
    assign o_big   = r_big[NS-1];
    assign o_neg   = r_neg[NS-1];

endmodule

### src/matrix3x3_inverse_unit.sv
// 3x3 fixed-point matrix inverse by adjugate over determinant, fully pipelined.
// Accepts one matrix per clock (busy stays low) and returns its inverse on a
// one-cycle o_result_valid strobe; the receiver cannot stall. The pipeline holds
// the 2 cofactor, 3 determinant, 1 prep and 33 divider stages plus the output
// register; the divider resolves one quotient bit per stage. A matrix with
// |det| at or below the tolerance returns zeros with o_invertible low.
module matrix3x3_inverse_unit import mi3_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [TOL_W-1:0]        i_cfg_data,
    input  logic signed [ELEM_W-1:0] i_in_c0_r0,
    input  logic signed [ELEM_W-1:0] i_in_c0_r1,
    input  logic signed [ELEM_W-1:0] i_in_c0_r2,
    input  logic signed [ELEM_W-1:0] i_in_c1_r0,
    input  logic signed [ELEM_W-1:0] i_in_c1_r1,
    input  logic signed [ELEM_W-1:0] i_in_c1_r2,
    input  logic signed [ELEM_W-1:0] i_in_c2_r0,
    input  logic signed [ELEM_W-1:0] i_in_c2_r1,
    input  logic signed [ELEM_W-1:0] i_in_c2_r2,
    output logic                    o_result_valid,
    output logic signed [Q_W-1:0]   o_inv_c0_r0,
    output logic signed [Q_W-1:0]   o_inv_c0_r1,
    output logic signed [Q_W-1:0]   o_inv_c0_r2,
    output logic signed [Q_W-1:0]   o_inv_c1_r0,
    output logic signed [Q_W-1:0]   o_inv_c1_r1,
    output logic signed [Q_W-1:0]   o_inv_c1_r2,
    output logic signed [Q_W-1:0]   o_inv_c2_r0,
    output logic signed [Q_W-1:0]   o_inv_c2_r1,
    output logic signed [Q_W-1:0]   o_inv_c2_r2,
    output logic                    o_invertible
);

    localparam int SH = 2 * FRAC_BITS;

    t_elem            mat [N_ELEM];
    logic             cf_valid;
    t_cof             cf_cof [N_ELEM];
    t_elem            cf_m0 [N_DIM];
    logic             dt_valid;
    t_det             dt_det;
    t_cof             dt_cof [N_ELEM];
    logic             dv_valid;
    logic             dv_sing;
    t_quo             dv_q [N_ELEM];
    logic             dv_big [N_ELEM];
    logic             dv_neg [N_ELEM];

    logic [TOL_W-1:0] r_tol;
    logic             r_pv;
    logic             r_psing;
    t_dabs            r_pd;
    t_wide            r_pnum [N_ELEM];
    logic             r_pneg [N_ELEM];
    logic             r_ov;
    logic             r_oinv;
    t_quo             r_out [N_ELEM];

    t_dabs            dabs;
    logic             det_neg;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    assign mat[0] = i_in_c0_r0;
    assign mat[1] = i_in_c0_r1;
    assign mat[2] = i_in_c0_r2;
    assign mat[3] = i_in_c1_r0;
    assign mat[4] = i_in_c1_r1;
    assign mat[5] = i_in_c1_r2;
    assign mat[6] = i_in_c2_r0;
    assign mat[7] = i_in_c2_r1;
    assign mat[8] = i_in_c2_r2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_W'(1);
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_data;
        end
    end

    mi3_cofactor u_cofactor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_mat   (mat),
        .o_valid (cf_valid),
        .o_cof   (cf_cof),
        .o_m0    (cf_m0)
    );

    mi3_det u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cf_valid),
        .i_cof   (cf_cof),
        .i_m0    (cf_m0),
        .o_valid (dt_valid),
        .o_det   (dt_det),
        .o_cof   (dt_cof)
    );

    // prep: magnitudes, signs, singular test and scaled numerators
    assign det_neg = dt_det[DET_W-1];
    assign dabs    = det_neg ? t_dabs'(-dt_det) : t_dabs'(dt_det);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= dt_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pd    <= dabs;
        r_psing <= WIDE_W'(dabs) <= (WIDE_W'(r_tol) << SH);
        for (int k = 0; k < N_ELEM; k++) begin
            r_pneg[k] <= dt_cof[k][COF_W-1] ^ det_neg;
            r_pnum[k] <= WIDE_W'(dt_cof[k][COF_W-1] ? t_cof'(-dt_cof[k]) : dt_cof[k]) << SH;
        end
    end

    mi3_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_pv),
        .i_sing  (r_psing),
        .i_d     (r_pd),
        .i_num   (r_pnum),
        .i_neg   (r_pneg),
        .o_valid (dv_valid),
        .o_sing  (dv_sing),
        .o_q     (dv_q),
        .o_big   (dv_big),
        .o_neg   (dv_neg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= dv_valid;
        end
    end

    // saturate and apply sign; zero every element for a singular matrix
    always_ff @(posedge i_clk) begin
        r_oinv <= ~dv_sing;
        for (int k = 0; k < N_ELEM; k++) begin
            if (dv_sing) begin
                r_out[k] <= '0;
            end else if (dv_neg[k]) begin
                if (dv_big[k] || dv_q[k] > SAT_NEG) begin
                    r_out[k] <= SAT_NEG;
                end else begin
                    r_out[k] <= -dv_q[k];
                end
            end else begin
                if (dv_big[k] || dv_q[k] > SAT_POS) begin
                    r_out[k] <= SAT_POS;
                end else begin
                    r_out[k] <= dv_q[k];
                end
            end
        end
    end

    assign o_result_valid = r_ov;
    assign o_invertible   = r_oinv;
    assign o_inv_c0_r0    = r_out[0];
    assign o_inv_c0_r1    = r_out[1];
    assign o_inv_c0_r2    = r_out[2];
    assign o_inv_c1_r0    = r_out[3];
    assign o_inv_c1_r1    = r_out[4];
    assign o_inv_c1_r2    = r_out[5];
    assign o_inv_c2_r0    = r_out[6];
    assign o_inv_c2_r1    = r_out[7];
    assign o_inv_c2_r2    = r_out[8];

endmodule
